>>> design/qle_pkg.sv
`timescale 1ns / 1ps

package qle_pkg;

  localparam int NUM_STATES    = 16;
  localparam int NUM_ACTIONS   = 4;
  localparam int VALUE_BITS    = 16;

  localparam int STATE_BITS    = $clog2(NUM_STATES);
  localparam int ACT_BITS      = $clog2(NUM_ACTIONS);
  localparam int TBL_DEPTH     = NUM_STATES * NUM_ACTIONS;
  localparam int TBL_ADDR_BITS = $clog2(TBL_DEPTH);
  localparam int RD_BITS       = $clog2(NUM_ACTIONS + 1);

  localparam int REWARD_BITS   = 16;
  localparam int RATE_BITS     = 16;
  localparam int Q_FRAC        = 16;
  localparam int ROUND_HALF    = 32768;

  localparam int P1_BITS  = VALUE_BITS + RATE_BITS + 1;
  localparam int D_BITS   = P1_BITS - Q_FRAC;
  localparam int ERR_BITS = ((D_BITS > REWARD_BITS) ? D_BITS : REWARD_BITS) + 2;
  localparam int P2_BITS  = ERR_BITS + RATE_BITS + 1;
  localparam int U_BITS   = P2_BITS - Q_FRAC;
  localparam int SUM_BITS = U_BITS + 1;

  localparam logic [1:0] CFG_LEARNING_RATE     = 2'd0;
  localparam logic [1:0] CFG_DISCOUNT          = 2'd1;
  localparam logic [1:0] CFG_EXPLORE_THRESHOLD = 2'd2;

  localparam logic [RATE_BITS-1:0] LEARNING_RATE_RST     = 16'd6554;
  localparam logic [RATE_BITS-1:0] DISCOUNT_RST          = 16'd58982;
  localparam logic [RATE_BITS-1:0] EXPLORE_THRESHOLD_RST = 16'd6554;

  typedef struct packed {
    logic [3:0]         prev_state;
    logic [1:0]         taken_action;
    logic signed [15:0] reward_value;
    logic [3:0]         next_state;
    logic [15:0]        explore_draw;
    logic [1:0]         random_choice;
  } qle_in_t;

  typedef struct packed {
    logic signed [15:0] updated_value;
    logic [1:0]         chosen_action;
    logic               explored;
  } qle_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MAX,
    ST_MULD,
    ST_ERR,
    ST_MULU,
    ST_WB,
    ST_PICK
  } qle_state_t;

  typedef struct packed {
    logic               load_item;
    logic               rd_en;
    logic [RD_BITS-1:0] rd_idx;
    logic               calc_max;
    logic               mul_d;
    logic               calc_err;
    logic               mul_u;
    logic               write_back;
    logic               load_out;
  } qle_cmd_t;

  typedef struct packed {
    logic out_free;
  } qle_sts_t;

  function automatic logic [STATE_BITS-1:0] state_wrap(logic [3:0] s);
    int v;
    v = int'(s);
    for (int k = 0; k < 8; k++) begin
      if (v >= NUM_STATES) begin
        v = v - NUM_STATES;
      end
    end
    return STATE_BITS'(v);
  endfunction

  function automatic logic [ACT_BITS-1:0] action_wrap(logic [1:0] a);
    int v;
    v = int'(a);
    for (int k = 0; k < 2; k++) begin
      if (v >= NUM_ACTIONS) begin
        v = v - NUM_ACTIONS;
      end
    end
    return ACT_BITS'(v);
  endfunction

  function automatic logic [TBL_ADDR_BITS-1:0] tbl_addr(logic [STATE_BITS-1:0] s,
                                                        logic [ACT_BITS-1:0] a);
    return TBL_ADDR_BITS'(int'(s) * NUM_ACTIONS + int'(a));
  endfunction

endpackage

>>> design/qle_ctrl.sv
`timescale 1ns / 1ps

module qle_ctrl
  import qle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  qle_sts_t sts,
  output qle_cmd_t cmd
);

  qle_state_t         state_r, state_nxt;
  logic [RD_BITS-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RD_BITS'(NUM_ACTIONS)) begin
          state_nxt = ST_MAX;
        end
      end
      ST_MAX:  state_nxt = ST_MULD;
      ST_MULD: state_nxt = ST_ERR;
      ST_ERR:  state_nxt = ST_MULU;
      ST_MULU: state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_PICK;
      ST_PICK: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_idx = cnt_r;
    in_stall   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_READ: cmd.rd_en      = 1'b1;
      ST_MAX:  cmd.calc_max   = 1'b1;
      ST_MULD: cmd.mul_d      = 1'b1;
      ST_ERR:  cmd.calc_err   = 1'b1;
      ST_MULU: cmd.mul_u      = 1'b1;
      ST_WB:   cmd.write_back = 1'b1;
      ST_PICK: cmd.load_out   = sts.out_free;
      default: cmd            = '0;
    endcase
  end

endmodule

>>> design/qle_datapath.sv
`timescale 1ns / 1ps

module qle_datapath
  import qle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  qle_cmd_t             cmd,
  output qle_sts_t             sts,
  input  qle_in_t              in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [RATE_BITS-1:0] cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qle_out_t             out_data
);

  logic [RATE_BITS-1:0] lr_r, disc_r, eps_r;

  qle_in_t item_r;
  logic [STATE_BITS-1:0] ps_idx, ns_idx;
  logic [ACT_BITS-1:0]   act_idx, rnd_idx;

  logic [VALUE_BITS-1:0]     mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]      valid_r;
  logic [VALUE_BITS-1:0]     mem_q_r;
  logic                      mem_v_r;
  logic [TBL_ADDR_BITS-1:0]  rd_addr, wr_addr;
  logic                      pend_r;
  logic [RD_BITS-1:0]        pend_idx_r;
  logic signed [VALUE_BITS-1:0] rd_val;

  logic signed [VALUE_BITS-1:0] row_r [NUM_ACTIONS];
  logic signed [VALUE_BITS-1:0] q_r, m_r, row_max;
  logic [ACT_BITS-1:0]          best_idx;

  logic signed [P1_BITS-1:0]  p1_r, p1_sum;
  logic signed [D_BITS-1:0]   d_val;
  logic signed [ERR_BITS-1:0] e_r;
  logic signed [P2_BITS-1:0]  p2_r, p2_sum;
  logic signed [U_BITS-1:0]   u_val;
  logic signed [SUM_BITS-1:0] sum_val;
  logic signed [VALUE_BITS-1:0] nv, nv_r;
  logic signed [31:0]           nv_ext;

  localparam logic signed [SUM_BITS-1:0] SAT_HI =
    SUM_BITS'((longint'(1) << (VALUE_BITS - 1)) - 1);
  localparam logic signed [SUM_BITS-1:0] SAT_LO =
    SUM_BITS'(-(longint'(1) << (VALUE_BITS - 1)));

  logic     out_valid_r;
  qle_out_t out_data_r;

  assign ps_idx  = state_wrap(item_r.prev_state);
  assign ns_idx  = state_wrap(item_r.next_state);
  assign act_idx = action_wrap(item_r.taken_action);
  assign rnd_idx = action_wrap(item_r.random_choice);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= LEARNING_RATE_RST;
      disc_r <= DISCOUNT_RST;
      eps_r  <= EXPLORE_THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEARNING_RATE:     lr_r   <= cfg_data;
        CFG_DISCOUNT:          disc_r <= cfg_data;
        CFG_EXPLORE_THRESHOLD: eps_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  // table: one read port, one write port, invalid entries read as zero
  assign wr_addr = tbl_addr(ps_idx, act_idx);
  assign rd_addr = (cmd.rd_idx == RD_BITS'(NUM_ACTIONS)) ? wr_addr
                 : tbl_addr(ns_idx, ACT_BITS'(cmd.rd_idx));

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_addr];
      mem_v_r <= valid_r[rd_addr];
    end
    if (cmd.write_back) begin
      mem[wr_addr] <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      pend_r     <= 1'b0;
      pend_idx_r <= '0;
    end else begin
      if (cmd.write_back) begin
        valid_r[wr_addr] <= 1'b1;
      end
      pend_r     <= cmd.rd_en;
      pend_idx_r <= cmd.rd_idx;
    end
  end

  assign rd_val = mem_v_r ? $signed(mem_q_r) : '0;

  always_ff @(posedge clk) begin
    if (pend_r) begin
      if (pend_idx_r == RD_BITS'(NUM_ACTIONS)) begin
        q_r <= rd_val;
      end else begin
        row_r[ACT_BITS'(pend_idx_r)] <= rd_val;
      end
    end
    if (cmd.write_back && (ps_idx == ns_idx)) begin
      row_r[act_idx] <= nv;
    end
  end

  always_comb begin
    row_max  = row_r[0];
    best_idx = '0;
    for (int a = 1; a < NUM_ACTIONS; a++) begin
      if (row_r[a] > row_max) begin
        row_max  = row_r[a];
        best_idx = ACT_BITS'(a);
      end
    end
  end

  assign p1_sum  = p1_r + P1_BITS'(ROUND_HALF);
  assign d_val   = D_BITS'(p1_sum >>> Q_FRAC);
  assign p2_sum  = p2_r + P2_BITS'(ROUND_HALF);
  assign u_val   = U_BITS'(p2_sum >>> Q_FRAC);
  assign sum_val = SUM_BITS'(q_r) + SUM_BITS'(u_val);

  always_comb begin
    if (sum_val > SAT_HI) begin
      nv = VALUE_BITS'(SAT_HI);
    end else if (sum_val < SAT_LO) begin
      nv = VALUE_BITS'(SAT_LO);
    end else begin
      nv = VALUE_BITS'(sum_val);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_max) begin
      m_r <= row_max;
    end
    if (cmd.mul_d) begin
      p1_r <= m_r * $signed({1'b0, disc_r});
    end
    if (cmd.calc_err) begin
      e_r <= ERR_BITS'(item_r.reward_value) + ERR_BITS'(d_val) - ERR_BITS'(q_r);
    end
    if (cmd.mul_u) begin
      p2_r <= e_r * $signed({1'b0, lr_r});
    end
    if (cmd.write_back) begin
      nv_r <= nv;
    end
  end

  assign nv_ext = 32'(nv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.updated_value <= nv_ext[15:0];
      if (item_r.explore_draw < eps_r) begin
        out_data_r.chosen_action <= 2'(rnd_idx);
        out_data_r.explored      <= 1'b1;
      end else begin
        out_data_r.chosen_action <= 2'(best_idx);
        out_data_r.explored      <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

endmodule

>>> design/tabular_q_learning_engine_core.sv
`timescale 1ns / 1ps

// Tabular Q-learning update with epsilon-greedy action pick. One transition
// item yields one result item; from acceptance to result an item passes an
// accept step, NUM_ACTIONS + 1 reads through the single registered table read
// port (the next state's row, then the entry being updated), a row maximum,
// the discount multiply, the error subtract, the learning-rate multiply, the
// write-back with saturation, and the greedy/explore pick. The next item is
// taken once the pick is done, while the result may still sit in the output
// register. The value table starts at zero after reset through per-entry
// valid bits, so no clearing pass is needed. cfg_ready is always high; write
// configuration only while no item is in flight.

module tabular_q_learning_engine_core
  import qle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  qle_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output qle_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [RATE_BITS-1:0] cfg_data
);

  qle_cmd_t cmd;
  qle_sts_t sts;

  assign cfg_ready = 1'b1;

  qle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qle_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/qle_transition_monitor.sv
`timescale 1ns / 1ps

module qle_transition_monitor
  import qle_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  qle_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  qle_out_t             out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [RATE_BITS-1:0] cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  longint               q_table [TBL_DEPTH];
  logic [RATE_BITS-1:0] lr_q16;
  logic [RATE_BITS-1:0] discount_q16;
  logic [RATE_BITS-1:0] epsilon_q16;
  qle_out_t             predicted_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic longint round_q16(longint x);
    return (x + ROUND_HALF) >>> Q_FRAC;
  endfunction

  function automatic qle_out_t apply_transition(qle_in_t item);
    int       row;
    int       slot;
    int       a;
    int       best;
    longint   peak;
    longint   q;
    longint   err;
    longint   nv;
    longint   hi;
    longint   lo;
    qle_out_t r;
    row  = int'(item.next_state % NUM_STATES) * NUM_ACTIONS;
    slot = int'(item.prev_state % NUM_STATES) * NUM_ACTIONS
           + int'(item.taken_action % NUM_ACTIONS);
    peak = q_table[row];
    for (a = 1; a < NUM_ACTIONS; a++) begin
      if (q_table[row + a] > peak) begin
        peak = q_table[row + a];
      end
    end
    q   = q_table[slot];
    err = longint'(item.reward_value) + round_q16(longint'(discount_q16) * peak) - q;
    nv  = q + round_q16(longint'(lr_q16) * err);
    hi  = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
    lo  = -hi - 1;
    if (nv > hi) begin
      nv = hi;
    end else if (nv < lo) begin
      nv = lo;
    end
    q_table[slot] = nv;
    best = 0;
    for (a = 1; a < NUM_ACTIONS; a++) begin
      if (q_table[row + a] > q_table[row + best]) begin
        best = a;
      end
    end
    r.updated_value = 16'(nv);
    if (item.explore_draw < epsilon_q16) begin
      r.chosen_action = 2'(item.random_choice % NUM_ACTIONS);
      r.explored      = 1'b1;
    end else begin
      r.chosen_action = 2'(best);
      r.explored      = 1'b0;
    end
    return r;
  endfunction

  task automatic flag(input string what, input qle_out_t want, input qle_out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected value=%0d action=%0d explored=%0b,", $time, what,
               want.updated_value, want.chosen_action, want.explored);
      $display("    got value=%0d action=%0d explored=%0b",
               got.updated_value, got.chosen_action, got.explored);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (q_table[i]) begin
        q_table[i] = 0;
      end
      lr_q16       = LEARNING_RATE_RST;
      discount_q16 = DISCOUNT_RST;
      epsilon_q16  = EXPLORE_THRESHOLD_RST;
      predicted_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEARNING_RATE:     lr_q16       = cfg_data;
          CFG_DISCOUNT:          discount_q16 = cfg_data;
          CFG_EXPLORE_THRESHOLD: epsilon_q16  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predicted_results.push_back(apply_transition(in_data));
      end
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          flag("unexpected item", '0, out_data);
        end else begin
          qle_out_t want;
          want = predicted_results.pop_front();
          if (out_data.updated_value !== want.updated_value ||
              out_data.chosen_action !== want.chosen_action ||
              out_data.explored !== want.explored) begin
            flag("mismatch", want, out_data);
          end
        end
      end
    end
    outstanding = predicted_results.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qle_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         PHASE_ITEMS = 322;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  qle_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  qle_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = '0;
  logic [RATE_BITS-1:0] cfg_data = '0;
  logic                 bursty = 1'b1;
  logic [RATE_BITS-1:0] cur_threshold = EXPLORE_THRESHOLD_RST;
  int                   mismatches;
  int                   outstanding;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tabular_q_learning_engine_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  qle_transition_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever begin
      @(negedge clk);
      out_stall <= bursty && ($urandom_range(99) < 11);
    end
  end

  // leaves cfg_valid high; caller lowers it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [RATE_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [RATE_BITS-1:0] lr, input logic [RATE_BITS-1:0] disc,
                           input logic [RATE_BITS-1:0] thr);
    write_reg(CFG_LEARNING_RATE, lr);
    write_reg(CFG_DISCOUNT, disc);
    write_reg(CFG_EXPLORE_THRESHOLD, thr);
    cfg_valid <= 1'b0;
    cur_threshold = thr;
  endtask

  task automatic settle();
    wait (outstanding == 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic send_item(input qle_in_t item);
    if (bursty && $urandom_range(99) < 11) begin
      repeat ($urandom_range(1, 14)) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic qle_in_t make_item(int ps, int act, int rew, int ns, int draw, int rnd);
    qle_in_t t;
    t.prev_state    = 4'(ps);
    t.taken_action  = 2'(act);
    t.reward_value  = 16'(rew);
    t.next_state    = 4'(ns);
    t.explore_draw  = 16'(draw);
    t.random_choice = 2'(rnd);
    return t;
  endfunction

  function automatic qle_in_t random_transition(logic [RATE_BITS-1:0] thr);
    qle_in_t t;
    t = qle_in_t'({$urandom, $urandom});
    if ($urandom_range(99) < 60) begin
      t.prev_state = 4'($urandom_range(3));
    end
    if ($urandom_range(99) < 25) begin
      t.next_state = t.prev_state;
    end else if ($urandom_range(99) < 50) begin
      t.next_state = 4'($urandom_range(3));
    end
    case ($urandom_range(3))
      0: t.reward_value = 16'($urandom_range(512)) - 16'd256;
      1: t.reward_value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: ;
    endcase
    if ($urandom_range(99) < 20) begin
      t.explore_draw = thr + 16'($urandom_range(2)) - 16'd1;
    end
    return t;
  endfunction

  initial begin
    logic [RATE_BITS-1:0] lr;
    logic [RATE_BITS-1:0] disc;
    logic [RATE_BITS-1:0] thr;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: ties, explore edges, same row
    send_item(make_item(0, 0, 32767, 15, 65535, 0));
    send_item(make_item(15, 3, -32768, 0, 0, 3));
    send_item(make_item(3, 1, 0, 3, 6553, 2));
    send_item(make_item(3, 1, 256, 3, 6554, 1));
    send_item(make_item(7, 2, -1, 7, 65535, 3));
    in_valid <= 1'b0;
    settle();

    // full rates, never explore; the write past the last register is dropped
    write_reg(CFG_UNUSED, 16'h1234);
    configure(16'hffff, 16'hffff, 16'h0000);
    @(negedge clk);
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      send_item(make_item(5, a, 32767, 5, 0, a));
    end
    send_item(make_item(5, 0, 32767, 5, 0, 0));
    send_item(make_item(6, 2, -32768, 9, 0, 1));
    send_item(make_item(6, 2, -32768, 9, 0, 1));
    for (int a = 0; a < NUM_ACTIONS; a++) begin
      send_item(make_item(9, a, -32768, 10, 0, a));
    end
    send_item(make_item(9, 0, -32768, 9, 0, 0));
    in_valid <= 1'b0;
    settle();

    for (int p = 0; p < 6; p++) begin
      lr   = 16'($urandom);
      disc = 16'($urandom);
      thr  = 16'($urandom);
      case (p)
        1: begin
          lr   = 16'h0000;
          disc = 16'hffff;
          thr  = 16'hffff;
        end
        2: begin
          lr   = 16'hffff;
          disc = 16'h0000;
          thr  = 16'h8000;
        end
        3: begin
          lr   = LEARNING_RATE_RST;
          disc = DISCOUNT_RST;
          thr  = EXPLORE_THRESHOLD_RST;
        end
        4: thr = 16'h0000;
        5: begin
          lr   = 16'hffff;
          disc = 16'hffff;
        end
        default: ;
      endcase
      configure(lr, disc, thr);
      @(negedge clk);
      bursty = (p != 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_transition(cur_threshold));
      end
      in_valid <= 1'b0;
      bursty = 1'b1;
      settle();
    end

    wait (outstanding == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[tabular_q_learning_engine_core] OK");
    end else begin
      $display("[tabular_q_learning_engine_core] ERROR");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[tabular_q_learning_engine_core] ERROR");
    $finish;
  end

endmodule

>>> tabular_q_learning_engine_core.f
design/qle_pkg.sv
design/qle_ctrl.sv
design/qle_datapath.sv
design/tabular_q_learning_engine_core.sv
tb/qle_transition_monitor.sv
tb/testbench.sv
